[rtl/roihs_pkg.sv]
`timescale 1ns / 1ps

package roihs_pkg;

    localparam int FIELD_W        = 12;
    localparam int NUM_FIELDS     = 4;
    localparam int FIELD_IDX_W    = $clog2(NUM_FIELDS);
    localparam int BIT_CNT_W      = $clog2(FIELD_W);
    localparam int ITEM_W         = FIELD_W * NUM_FIELDS;
    localparam int RING_DEPTH_DEF = 8;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SUM,
        S_LOAD,
        S_DIV,
        S_OUT
    } t_state;

endpackage

[rtl/roi_history_smoother_top.sv]
`timescale 1ns / 1ps

// Region-of-interest smoother. Each item on the slave stream carries one region
// (x, y, w, h; 12 bits each). The region is written into a history ring of the
// last RING_DEPTH regions, and each field of the new smoothed region is the
// previous smoothed value plus the sum over the stored regions, divided by the
// number of stored regions plus one, truncated. One item on the master stream
// carries that smoothed region.
// Flow: s_axis_tready is high only while the block is idle. After an item is
// accepted the history walk reads the N stored regions (N = stored regions, one
// ring read per cycle), then one shared restoring divider produces the four
// fields one after another (one quotient bit per cycle after a load step per
// field), and the result then moves into the output register. Only then does
// the block return to idle, so the next item is accepted only once the result
// of the last one is in the output register.
// The result stays on m_axis_tdata with m_axis_tvalid high until the receiver
// takes it. The next item is accepted and processed meanwhile; its result waits
// inside, with s_axis_tready low, until the output register is free.
// Reset clears the smoothed region to zero and empties the ring and the output
// register; the ring storage itself needs no clearing pass.
module roi_history_smoother_top #(
    parameter int RING_DEPTH = roihs_pkg::RING_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // roi_x [11:0], roi_y [23:12], roi_w [35:24], roi_h [47:36]
    input  logic [roihs_pkg::ITEM_W-1:0] s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // smooth_x [11:0], smooth_y [23:12], smooth_w [35:24], smooth_h [47:36]
    output logic [roihs_pkg::ITEM_W-1:0] m_axis_tdata
);

    import roihs_pkg::*;

    localparam int CNT_W = $clog2(RING_DEPTH + 1);
    localparam int PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int DIV_W = $clog2(RING_DEPTH + 2);
    localparam int SUM_W = FIELD_W + DIV_W;

    t_state                 r_state, n_state;
    logic [CNT_W-1:0]       r_fill, n_fill;
    logic [PTR_W-1:0]       r_wptr, n_wptr;
    logic [CNT_W-1:0]       r_idx, n_idx;
    logic                   r_rd_vld, n_rd_vld;
    logic [ITEM_W-1:0]      r_rd_data;
    logic [SUM_W-1:0]       r_acc [NUM_FIELDS];
    logic [SUM_W-1:0]       n_acc [NUM_FIELDS];
    logic [FIELD_W-1:0]     r_smooth [NUM_FIELDS];
    logic [FIELD_W-1:0]     n_smooth [NUM_FIELDS];
    logic [FIELD_IDX_W-1:0] r_field, n_field;
    logic [BIT_CNT_W-1:0]   r_bit, n_bit;
    logic [DIV_W-1:0]       r_rem, n_rem;
    logic [FIELD_W-1:0]     r_quo, n_quo;
    logic                   r_out_vld, n_out_vld;
    logic [ITEM_W-1:0]      r_out_data;

    logic [ITEM_W-1:0]      r_ring [RING_DEPTH];

    logic                   w_accept;
    logic                   w_rd_en;
    logic                   w_out_load;
    logic [ITEM_W-1:0]      w_smooth_flat;
    logic [DIV_W-1:0]       w_div;
    logic [DIV_W:0]         w_part;
    logic [DIV_W+1:0]       w_diff;

    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_div         = DIV_W'(r_fill) + DIV_W'(1);
    assign w_part        = {r_rem, r_quo[FIELD_W-1]};
    assign w_diff        = {1'b0, w_part} - (DIV_W + 2)'(w_div);
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_ring[r_wptr] <= s_axis_tdata;
        end
        if (w_rd_en) begin
            r_rd_data <= r_ring[r_idx[PTR_W-1:0]];
        end
    end

    always_comb begin
        n_state    = r_state;
        n_fill     = r_fill;
        n_wptr     = r_wptr;
        n_idx      = r_idx;
        n_rd_vld   = 1'b0;
        n_acc      = r_acc;
        n_smooth   = r_smooth;
        n_field    = r_field;
        n_bit      = r_bit;
        n_rem      = r_rem;
        n_quo      = r_quo;
        n_out_vld  = r_out_vld && !m_axis_tready;
        w_rd_en    = 1'b0;
        w_out_load = 1'b0;
        s_axis_tready = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    n_wptr = (r_wptr == PTR_W'(RING_DEPTH - 1)) ? '0 : r_wptr + PTR_W'(1);
                    if (r_fill != CNT_W'(RING_DEPTH)) begin
                        n_fill = r_fill + CNT_W'(1);
                    end
                    for (int f = 0; f < NUM_FIELDS; f++) begin
                        n_acc[f] = SUM_W'(r_smooth[f]);
                    end
                    n_idx   = '0;
                    n_state = S_SUM;
                end
            end
            S_SUM: begin
                if (r_idx != r_fill) begin
                    w_rd_en  = 1'b1;
                    n_rd_vld = 1'b1;
                    n_idx    = r_idx + CNT_W'(1);
                end
                if (r_rd_vld) begin
                    for (int f = 0; f < NUM_FIELDS; f++) begin
                        n_acc[f] = r_acc[f] + SUM_W'(r_rd_data[f*FIELD_W +: FIELD_W]);
                    end
                end
                if ((r_idx == r_fill) && !r_rd_vld) begin
                    n_field = '0;
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                n_rem   = r_acc[r_field][SUM_W-1:FIELD_W];
                n_quo   = r_acc[r_field][FIELD_W-1:0];
                n_bit   = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                if (w_diff[DIV_W+1]) begin
                    n_rem = w_part[DIV_W-1:0];
                    n_quo = {r_quo[FIELD_W-2:0], 1'b0};
                end else begin
                    n_rem = w_diff[DIV_W-1:0];
                    n_quo = {r_quo[FIELD_W-2:0], 1'b1};
                end
                n_bit = r_bit + BIT_CNT_W'(1);
                if (r_bit == BIT_CNT_W'(FIELD_W - 1)) begin
                    n_smooth[r_field] = n_quo;
                    if (r_field == FIELD_IDX_W'(NUM_FIELDS - 1)) begin
                        n_state = S_OUT;
                    end else begin
                        n_field = r_field + FIELD_IDX_W'(1);
                        n_state = S_LOAD;
                    end
                end
            end
            S_OUT: begin
                if (!r_out_vld || m_axis_tready) begin
                    w_out_load = 1'b1;
                    n_out_vld  = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_fill    <= '0;
            r_wptr    <= '0;
            r_idx     <= '0;
            r_rd_vld  <= 1'b0;
            r_field   <= '0;
            r_bit     <= '0;
            r_out_vld <= 1'b0;
            for (int f = 0; f < NUM_FIELDS; f++) begin
                r_smooth[f] <= '0;
            end
        end else begin
            r_state   <= n_state;
            r_fill    <= n_fill;
            r_wptr    <= n_wptr;
            r_idx     <= n_idx;
            r_rd_vld  <= n_rd_vld;
            r_field   <= n_field;
            r_bit     <= n_bit;
            r_out_vld <= n_out_vld;
            r_smooth  <= n_smooth;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        r_rem <= n_rem;
        r_quo <= n_quo;
        if (w_out_load) begin
            r_out_data <= w_smooth_flat;
        end
    end

    always_comb begin
        for (int f = 0; f < NUM_FIELDS; f++) begin
            w_smooth_flat[f*FIELD_W +: FIELD_W] = r_smooth[f];
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("pending result dropped or changed");

    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CNT_W'(RING_DEPTH))
        else $error("fill count beyond ring depth");

    a_ptr_tracks_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill != CNT_W'(RING_DEPTH)) |-> (CNT_W'(r_wptr) == r_fill))
        else $error("write pointer out of step with fill count");

    a_accept_to_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_SUM))
        else $error("accepted item did not start the history walk");

    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < w_div))
        else $error("partial remainder not below divisor");

endmodule

[dv/roi_history_smoother_top_test.sv]
`timescale 1ns / 1ps

module roi_history_smoother_top_test;

    import roihs_pkg::*;

    localparam int RING_DEPTH    = RING_DEPTH_DEF;
    localparam int DIR_ROWS      = 15;
    localparam int PHASE_ITEMS   = 362;
    localparam int SETTLE_CYCLES = 70;

    typedef logic [FIELD_W-1:0] t_coord;
    typedef logic [NUM_FIELDS-1:0][FIELD_W-1:0] t_region;

    typedef struct packed {
        t_region roi;
        logic    known;
        t_region result;
    } t_dir_row;

    logic                 i_clk;
    logic                 i_rst_n       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [ITEM_W-1:0]    s_axis_tdata  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [ITEM_W-1:0]    m_axis_tdata;

    int unsigned          send_idle_pct = 28;
    int unsigned          recv_idle_pct = 81;
    int unsigned          mismatches    = 0;

    t_region              expected_regions [$];
    t_region              history_ring [RING_DEPTH];
    int unsigned          history_fill  = 0;
    int unsigned          history_wr    = 0;
    t_region              smoothed      = '0;
    t_region              last_roi      = '0;
    string                field_names [NUM_FIELDS] = '{"x", "y", "w", "h"};

    // Literals are h_w_y_x, so x sits in the lowest bits as on the bus.
    t_dir_row dir_table [DIR_ROWS] = '{
        '{48'hFFF_FFF_FFF_FFF, 1'b1, 48'h7FF_7FF_7FF_7FF},
        '{48'h000_000_000_000, 1'b1, 48'h7FF_7FF_7FF_7FF},
        '{48'h000_000_000_000, 1'b1, 48'h5FF_5FF_5FF_5FF},
        '{48'h123_456_789_ABC, 1'b0, 48'h000_000_000_000},
        '{48'hFFF_000_FFF_000, 1'b0, 48'h000_000_000_000},
        '{48'h000_FFF_000_FFF, 1'b0, 48'h000_000_000_000},
        '{48'hAAA_555_AAA_555, 1'b0, 48'h000_000_000_000},
        '{48'h555_AAA_555_AAA, 1'b0, 48'h000_000_000_000},
        '{48'h001_800_001_800, 1'b0, 48'h000_000_000_000},
        '{48'h800_001_800_001, 1'b0, 48'h000_000_000_000},
        '{48'h0FF_F00_F0F_0F0, 1'b0, 48'h000_000_000_000},
        '{48'hFFF_FFF_FFF_FFF, 1'b0, 48'h000_000_000_000},
        '{48'hFFF_FFF_FFF_FFF, 1'b0, 48'h000_000_000_000},
        '{48'h000_000_000_000, 1'b0, 48'h000_000_000_000},
        '{48'h3E8_2D0_140_0F0, 1'b0, 48'h000_000_000_000}
    };

    roi_history_smoother_top #(
        .RING_DEPTH    (RING_DEPTH)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #4_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic t_region smooth_update(input t_region roi);
        logic [31:0] acc;
        t_region     res;
        history_ring[history_wr] = roi;
        history_wr = (history_wr + 1) % RING_DEPTH;
        if (history_fill < RING_DEPTH) begin
            history_fill++;
        end
        for (int f = 0; f < NUM_FIELDS; f++) begin
            acc = 32'(smoothed[f]);
            for (int e = 0; e < history_fill; e++) begin
                acc += 32'(history_ring[e][f]);
            end
            res[f] = t_coord'(acc / (history_fill + 1));
        end
        smoothed = res;
        return res;
    endfunction

    function automatic t_coord pick_coord(input t_coord prev);
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            2, 3, 4: return prev ^ t_coord'($urandom_range(15));
            default: return t_coord'($urandom_range(4095));
        endcase
    endfunction

    task automatic flag_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_region(input t_region got);
        t_region want;
        if (expected_regions.size() == 0) begin
            flag_mismatch($sformatf("unexpected region %h", got));
        end else begin
            want = expected_regions.pop_front();
            for (int f = 0; f < NUM_FIELDS; f++) begin
                if (got[f] !== want[f]) begin
                    flag_mismatch($sformatf("smooth_%s got %0d, expected %0d",
                                            field_names[f], got[f], want[f]));
                end
            end
        end
    endtask

    task automatic send_region(input t_region roi, input logic known,
                               input t_region result);
        t_region predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= roi;
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
        predicted = smooth_update(roi);
        expected_regions.push_back(known ? result : predicted);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (expected_regions.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            check_region(m_axis_tdata);
        end
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    initial begin
        t_region roi;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_table[i]) begin
            send_region(dir_table[i].roi, dir_table[i].known, dir_table[i].result);
        end
        last_roi = dir_table[DIR_ROWS-1].roi;
        drain_results();

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 28;
                    recv_idle_pct = 81;
                end
                1: begin
                    send_idle_pct = 81;
                    recv_idle_pct = 28;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            repeat (PHASE_ITEMS) begin
                for (int f = 0; f < NUM_FIELDS; f++) begin
                    roi[f] = pick_coord(last_roi[f]);
                end
                last_roi = roi;
                send_region(roi, 1'b0, '0);
            end
            drain_results();
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && expected_regions.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
